@@ sv/osa_pkg.sv @@
// package for the osa edit distance block: sizes, action codes, link structs
// used by osa_if.sv, osa_cell.sv and osa_damerau_edit_distance.sv
// no dependencies
package osa_pkg;

    localparam int MAX_LEN     = 32;
    localparam int SYMBOL_BITS = 8;

    // string length counters run 0..MAX_LEN
    localparam int LEN_W      = $clog2(MAX_LEN + 1);
    // row values stay at or below MAX_LEN, candidates reach MAX_LEN + 1
    localparam int DIST_W     = $clog2(MAX_LEN + 2);
    localparam int CELL_IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    typedef logic [SYMBOL_BITS-1:0] t_sym;
    typedef logic [LEN_W-1:0]       t_len;
    typedef logic [DIST_W-1:0]      t_dist;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_REF   = 2'd1,
        ACT_TGT   = 2'd2,
        ACT_END   = 2'd3
    } t_action;

    // values handed from one cell to its right-hand neighbour
    typedef struct packed {
        logic  tok;     // wavefront token
        t_dist val;     // new row entry of the sender
        t_dist prev;    // old previous row entry of the sender
        t_dist pp;      // old row-before-previous entry of the sender
        t_dist pp_l;    // old row-before-previous entry two places back
        t_sym  sym;     // reference symbol of the sender
        logic  sym_ok;  // sender is a real reference position
    } t_link;

    // per-row values broadcast to all cells while a target symbol is swept
    typedef struct packed {
        t_sym sym;       // current target symbol
        t_sym last;      // previous target symbol
        logic trans_en;  // transposition check allowed for this row
    } t_bcast;

endpackage

@@ sv/osa_if.sv @@
// channel interfaces of the osa edit distance block
// depends on osa_pkg
interface osa_in_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                action;
    logic [osa_pkg::SYMBOL_BITS-1:0] symbol;

    modport source (output valid, output action, output symbol, input ready);
    modport sink   (input valid, input action, input symbol, output ready);
endinterface

interface osa_out_if;
    logic                         valid;
    logic                         ready;
    logic [osa_pkg::DIST_W-1:0]   distance;
    logic                         too_long;

    modport source (output valid, output distance, output too_long, input ready);
    modport sink   (input valid, input distance, input too_long, output ready);
endinterface

interface osa_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/osa_damerau_edit_distance.sv @@
// top level of the osa (damerau) / levenshtein edit distance block
// depends on osa_pkg, osa_if.sv (osa_in_if, osa_out_if, osa_cfg_if), osa_cell
//
// usage
//   i_in carries requests of (action, symbol): start clears the pair, reference
//   requests load the reference string one symbol each, target requests each
//   sweep one dynamic-programming row, end queues one result on o_out
//   o_out carries (distance, too_long), held in one output register
//   i_cfg writes allow_transpositions (bit 0 of data); the user must write it only
//   while the block is idle, the block itself does not enforce this
//   an end result is visible on o_out the cycle after its request is accepted
//   a target request holds i_in off until its row is complete: the wavefront
//   token walks the used cells of the chain one position per cycle
// reset
//   synchronous active-low i_rst_n gives the cleared pair state and
//   allow_transpositions = 1; no clearing pass is needed
// stalls
//   while a result waits on o_out, start/reference/target requests are still
//   taken; a further end request waits until the pending result is taken
module osa_damerau_edit_distance (
    input  logic            i_clk,
    input  logic            i_rst_n,
    osa_cfg_if.sink         i_cfg,
    osa_in_if.sink          i_in,
    osa_out_if.source       o_out
);

    // pair state held outside the cells
    osa_pkg::t_len   r_ref_len;
    osa_pkg::t_len   r_tgt_len;
    osa_pkg::t_sym   r_last_sym;
    logic            r_ovf;
    logic            r_allow;
    osa_pkg::t_len   r_busy_cnt;

    // per-sweep values: broadcast and left boundary (entry 0 of the rows)
    osa_pkg::t_bcast r_bc;
    osa_pkg::t_link  r_bnd;

    // output register
    logic            r_out_vld;
    osa_pkg::t_dist  r_out_dist;
    logic            r_out_long;

    logic            w_idle;
    logic            w_in_acc;
    logic            w_out_free;
    osa_pkg::t_action w_act;
    logic            w_start_go;
    logic            w_ref_go;
    logic            w_ref_ovf;
    logic            w_tgt_go;
    logic            w_tgt_ovf;
    logic            w_end_go;
    osa_pkg::t_dist  w_pp0;
    osa_pkg::t_len   w_len_m1;
    logic [osa_pkg::CELL_IDX_W-1:0] w_rd_idx;
    logic [osa_pkg::CELL_IDX_W-1:0] w_wr_idx;
    osa_pkg::t_dist  w_dist;

    osa_pkg::t_link  w_link [osa_pkg::MAX_LEN+1];
    osa_pkg::t_dist  w_prev [osa_pkg::MAX_LEN];
    logic [osa_pkg::MAX_LEN:0] w_tok_vec;

    // handshakes
    assign w_idle     = (r_busy_cnt == '0);
    assign w_act      = osa_pkg::t_action'(i_in.action);
    assign w_out_free = !r_out_vld || o_out.ready;
    assign i_in.ready = w_idle && ((w_act != osa_pkg::ACT_END) || w_out_free);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    // decode the accepted request
    always_comb begin
        w_start_go = 1'b0;
        w_ref_go   = 1'b0;
        w_ref_ovf  = 1'b0;
        w_tgt_go   = 1'b0;
        w_tgt_ovf  = 1'b0;
        w_end_go   = 1'b0;
        if (w_in_acc) begin
            unique case (w_act)
                osa_pkg::ACT_START: w_start_go = 1'b1;
                osa_pkg::ACT_REF: begin
                    // reference symbols after the first target symbol are dropped silently
                    if (r_tgt_len == '0) begin
                        if (r_ref_len >= osa_pkg::t_len'(osa_pkg::MAX_LEN)) begin
                            w_ref_ovf = 1'b1;
                        end else begin
                            w_ref_go = 1'b1;
                        end
                    end
                end
                osa_pkg::ACT_TGT: begin
                    if (r_tgt_len >= osa_pkg::t_len'(osa_pkg::MAX_LEN)) begin
                        w_tgt_ovf = 1'b1;
                    end else begin
                        w_tgt_go = 1'b1;
                    end
                end
                osa_pkg::ACT_END: w_end_go = 1'b1;
                default: ;
            endcase
        end
    end

    // entry 0 of the row before previous: target length less one, floor zero
    assign w_pp0 = (r_tgt_len == '0) ? '0
                 : osa_pkg::t_dist'(r_tgt_len - osa_pkg::t_len'(1));

    // distance is entry reference_length of the previous row
    assign w_len_m1 = r_ref_len - osa_pkg::t_len'(1);
    assign w_rd_idx = w_len_m1[osa_pkg::CELL_IDX_W-1:0];
    assign w_wr_idx = r_ref_len[osa_pkg::CELL_IDX_W-1:0];
    assign w_dist   = (r_ref_len == '0) ? osa_pkg::t_dist'(r_tgt_len) : w_prev[w_rd_idx];

    // control state and left boundary of the sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_len  <= '0;
            r_tgt_len  <= '0;
            r_last_sym <= '0;
            r_ovf      <= 1'b0;
            r_allow    <= 1'b1;
            r_busy_cnt <= '0;
            r_bnd      <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_allow <= i_cfg.data;
            end
            r_bnd.tok <= w_tgt_go;
            if (w_tgt_go) begin
                // busy counter starts at the number of used cells, counts down until the row is complete
                r_busy_cnt <= r_ref_len;
            end else if (!w_idle) begin
                r_busy_cnt <= r_busy_cnt - osa_pkg::t_len'(1);
            end
            if (w_start_go) begin
                r_ref_len  <= '0;
                r_tgt_len  <= '0;
                r_last_sym <= '0;
                r_ovf      <= 1'b0;
            end
            if (w_ref_go) begin
                r_ref_len <= r_ref_len + osa_pkg::t_len'(1);
            end
            if (w_ref_ovf || w_tgt_ovf) begin
                r_ovf <= 1'b1;
            end
            if (w_tgt_go) begin
                r_tgt_len    <= r_tgt_len + osa_pkg::t_len'(1);
                r_last_sym   <= i_in.symbol;
                r_bnd.val    <= osa_pkg::t_dist'(r_tgt_len + osa_pkg::t_len'(1));
                r_bnd.prev   <= osa_pkg::t_dist'(r_tgt_len);
                r_bnd.pp     <= w_pp0;
                r_bnd.pp_l   <= '0;
                r_bnd.sym    <= '0;
                r_bnd.sym_ok <= 1'b0;
            end
            if (w_end_go) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // sweep payload: latched at the target request, stable for the whole sweep; result latched at end
    always_ff @(posedge i_clk) begin
        if (w_tgt_go) begin
            r_bc.sym      <= i_in.symbol;
            r_bc.last     <= r_last_sym;
            r_bc.trans_en <= r_allow && (r_tgt_len != '0);
        end
        if (w_end_go) begin
            r_out_dist <= w_dist;
            r_out_long <= r_ovf;
        end
    end

    // chain of cells, cell g holds reference position g + 1
    assign w_link[0] = r_bnd;

    genvar g;
    generate
        for (g = 0; g < osa_pkg::MAX_LEN; g++) begin : g_cell
            osa_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_clear    (w_start_go),
                .i_load     (w_ref_go && (w_wr_idx == osa_pkg::CELL_IDX_W'(g))),
                .i_load_sym (i_in.symbol),
                .i_init     (osa_pkg::t_dist'(g + 1)),
                .i_bc       (r_bc),
                .i_link     (w_link[g]),
                .o_link     (w_link[g+1]),
                .o_prev     (w_prev[g])
            );
        end
        for (g = 0; g <= osa_pkg::MAX_LEN; g++) begin : g_tok
            assign w_tok_vec[g] = w_link[g].tok;
        end
    endgenerate

    assign o_out.valid    = r_out_vld;
    assign o_out.distance = r_out_dist;
    assign o_out.too_long = r_out_long;

    // at most one wavefront is ever travelling along the chain
    a_one_wave: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok_vec))
        else $error("more than one wavefront token in the cell chain");

    // the sweep never outlasts the loaded reference
    a_busy_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy_cnt <= r_ref_len)
        else $error("sweep counter beyond reference length");

    // a target over a non-empty reference holds off further requests
    a_tgt_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tgt_go && (r_ref_len != '0)) |=> !w_idle)
        else $error("target sweep did not block the input");

endmodule

@@ sv/osa_cell.sv @@
// one reference position of the edit distance row: holds its symbol and two
// row entries, updates them when the wavefront token passes
// depends on osa_pkg
module osa_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_clear,
    input  logic            i_load,
    input  osa_pkg::t_sym   i_load_sym,
    input  osa_pkg::t_dist  i_init,
    input  osa_pkg::t_bcast i_bc,
    input  osa_pkg::t_link  i_link,
    output osa_pkg::t_link  o_link,
    output osa_pkg::t_dist  o_prev
);

    osa_pkg::t_sym  r_sym;
    logic           r_used;
    osa_pkg::t_dist r_prev;
    osa_pkg::t_dist r_pp;
    logic           r_tok;
    osa_pkg::t_dist r_val_out;
    osa_pkg::t_dist r_prev_out;
    osa_pkg::t_dist r_pp_out;
    osa_pkg::t_dist r_ppl_out;

    logic           w_act;
    logic           w_cost;
    logic           w_swap;
    osa_pkg::t_dist w_ins;
    osa_pkg::t_dist w_sub;
    osa_pkg::t_dist w_del;
    osa_pkg::t_dist w_trn;
    osa_pkg::t_dist w_min_a;
    osa_pkg::t_dist w_min_b;
    osa_pkg::t_dist n_val;

    always_comb begin
        w_act   = i_link.tok && r_used;
        w_cost  = (r_sym != i_bc.sym);
        w_ins   = i_link.val + osa_pkg::t_dist'(1);
        w_sub   = i_link.prev + osa_pkg::t_dist'(w_cost);
        w_del   = r_prev + osa_pkg::t_dist'(1);
        w_trn   = i_link.pp_l + osa_pkg::t_dist'(1);
        w_swap  = i_bc.trans_en && i_link.sym_ok &&
                  (r_sym == i_bc.last) && (i_link.sym == i_bc.sym);
        w_min_a = (w_sub < w_del) ? w_sub : w_del;
        w_min_b = (w_ins < w_min_a) ? w_ins : w_min_a;
        n_val   = (w_swap && (w_trn < w_min_b)) ? w_trn : w_min_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_used <= 1'b0;
            r_prev <= i_init;
            r_pp   <= i_init;
            r_tok  <= 1'b0;
        end else begin
            r_tok <= w_act;
            if (i_load) begin
                r_used <= 1'b1;
            end
            if (w_act) begin
                r_prev <= n_val;
                r_pp   <= r_prev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sym <= i_load_sym;
        end
        if (w_act) begin
            r_val_out  <= n_val;
            r_prev_out <= r_prev;
            r_pp_out   <= r_pp;
            r_ppl_out  <= i_link.pp;
        end
    end

    always_comb begin
        o_link.tok    = r_tok;
        o_link.val    = r_val_out;
        o_link.prev   = r_prev_out;
        o_link.pp     = r_pp_out;
        o_link.pp_l   = r_ppl_out;
        o_link.sym    = r_sym;
        o_link.sym_ok = 1'b1;
    end

    assign o_prev = r_prev;

endmodule
